@@ hw/rtl/lag_pkg.sv @@
// ----------------------------------------------------------------------------
// lag_pkg
// shared types and constants of the life automaton grid
// ----------------------------------------------------------------------------
package lag_pkg;

    localparam int MAX_COLS_DEF = 64;
    localparam int MAX_ROWS_DEF = 64;

    localparam int FUNC_W = 2;
    localparam int CELL_W = 6;
    localparam int CFG_W  = 7;
    localparam int LIVE_W = 13;
    localparam int GEN_W  = 32;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [CFG_W-1:0]  CFG_DIM_RST = 7'd64;
    localparam logic [LIVE_W-1:0] LIVE_MAX    = 13'h1FFF;

    localparam logic CFG_COLS = 1'b0;
    localparam logic CFG_ROWS = 1'b1;

    typedef enum logic [FUNC_W-1:0] {
        FN_TOGGLE = 2'd0,
        FN_CLEAR  = 2'd1,
        FN_TICK   = 2'd2,
        FN_READ   = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TICK,
        ST_FETCH,
        ST_DONE
    } t_state;

endpackage

@@ hw/rtl/life_automaton_grid.sv @@
// ----------------------------------------------------------------------------
// life_automaton_grid
// game of life grid (birth on 3, survival on 2 or 3) held in two cell rams
// ----------------------------------------------------------------------------
// Commands are taken on start while busy is low; every command returns one
// word, strobed on o_done for a single cycle, and the receiver cannot stall
// it. Toggle and read pass through the fetch and done states before the
// strobe. A clear and a generation step both sweep over every ram address
// at one cell per cycle; a clear writes both rams, a generation step reads
// the front grid ram through its single read port and first fills the
// neighbourhood window before it writes the next grid into the other ram.
// After reset the block runs a clearing pass with busy high before the
// first command is taken; register writes are accepted throughout.
// ----------------------------------------------------------------------------
module life_automaton_grid
    import lag_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [FUNC_W-1:0] i_func,
    input  logic [CELL_W-1:0] i_cell_col,
    input  logic [CELL_W-1:0] i_cell_row,
    output logic              o_done,
    output logic              o_cell_alive,
    output logic [LIVE_W-1:0] o_living_total,
    output logic [GEN_W-1:0]  o_generation_number,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int CELLS     = MAX_COLS * MAX_ROWS;
    localparam int AW        = $clog2(CELLS);
    localparam int CW        = $clog2(MAX_COLS + 1);
    localparam int RW        = $clog2(MAX_ROWS + 1);
    localparam int CXW       = $clog2(MAX_COLS);
    localparam int RXW       = $clog2(MAX_ROWS);
    localparam int SR_LEN    = 2 * MAX_COLS + 3;
    localparam int WR_START  = MAX_COLS + 3;
    localparam int TICK_LAST = CELLS + MAX_COLS + 2;
    localparam int SW        = $clog2(TICK_LAST + 1);

    localparam int K_SE = 0;
    localparam int K_S  = 1;
    localparam int K_SW = 2;
    localparam int K_E  = MAX_COLS;
    localparam int K_C  = MAX_COLS + 1;
    localparam int K_W  = MAX_COLS + 2;
    localparam int K_NE = 2 * MAX_COLS;
    localparam int K_N  = 2 * MAX_COLS + 1;
    localparam int K_NW = 2 * MAX_COLS + 2;

    t_state             r_state, n_state;
    logic [SW-1:0]      r_cnt, n_cnt;
    logic               r_report, n_report;
    logic               r_front_b, n_front_b;
    logic [LIVE_W-1:0]  r_live, n_live;
    logic [LIVE_W-1:0]  r_acc, n_acc;
    logic [GEN_W-1:0]   r_gen, n_gen;
    logic [RXW-1:0]     r_crow, n_crow;
    logic [CXW-1:0]     r_ccol, n_ccol;
    logic [AW-1:0]      r_cidx, n_cidx;
    logic [SR_LEN-1:0]  r_sr, n_sr;
    logic               r_rd_v, n_rd_v;
    logic               r_done, n_done;
    logic               r_alive, n_alive;
    t_func              r_func, n_func;
    logic               r_inside, n_inside;
    logic [AW-1:0]      r_idx, n_idx;
    logic [CFG_W-1:0]   r_cols, n_cols;
    logic [CFG_W-1:0]   r_rows, n_rows;

    logic [CW-1:0]      w_cols;
    logic [RW-1:0]      w_rows;
    logic               w_accept;
    logic               w_inside;
    logic               w_cfg_wr;
    logic               w_up, w_dn, w_lf, w_rt;
    logic               w_in_area;
    logic [3:0]         w_nsum;
    logic               w_next;
    logic [LIVE_W-1:0]  w_acc_inc;
    logic               w_front_rd;
    logic               w_rd_a, w_rd_b;
    logic               w_we_a, w_we_b;
    logic [AW-1:0]      w_waddr;
    logic               w_wdata;
    logic [AW-1:0]      w_raddr;

    // area in use
    always_comb begin
        if (r_cols == '0) begin
            w_cols = CW'(1);
        end else if (32'(r_cols) > MAX_COLS) begin
            w_cols = CW'(MAX_COLS);
        end else begin
            w_cols = CW'(r_cols);
        end
        if (r_rows == '0) begin
            w_rows = RW'(1);
        end else if (32'(r_rows) > MAX_ROWS) begin
            w_rows = RW'(MAX_ROWS);
        end else begin
            w_rows = RW'(r_rows);
        end
    end

    assign w_accept = start && (r_state == ST_IDLE);
    assign w_inside = (32'(i_cell_col) < 32'(w_cols)) && (32'(i_cell_row) < 32'(w_rows));
    assign w_cfg_wr = psel && penable && pwrite && pready;

    // neighbourhood window of the generation sweep
    assign w_up      = (r_crow != '0);
    assign w_dn      = (32'(r_crow) + 32'd1) < 32'(w_rows);
    assign w_lf      = (r_ccol != '0);
    assign w_rt      = (32'(r_ccol) + 32'd1) < 32'(w_cols);
    assign w_in_area = (32'(r_crow) < 32'(w_rows)) && (32'(r_ccol) < 32'(w_cols));

    always_comb begin
        w_nsum = 4'(r_sr[K_NW] && w_up && w_lf)
               + 4'(r_sr[K_N]  && w_up)
               + 4'(r_sr[K_NE] && w_up && w_rt)
               + 4'(r_sr[K_W]  && w_lf)
               + 4'(r_sr[K_E]  && w_rt)
               + 4'(r_sr[K_SW] && w_dn && w_lf)
               + 4'(r_sr[K_S]  && w_dn)
               + 4'(r_sr[K_SE] && w_dn && w_rt);
    end

    assign w_next    = w_in_area && ((w_nsum == 4'd3) || (r_sr[K_C] && (w_nsum == 4'd2)));
    assign w_acc_inc = (r_acc == LIVE_MAX) ? r_acc : r_acc + LIVE_W'(w_next);
    assign w_front_rd = r_front_b ? w_rd_b : w_rd_a;

    lag_ram #(
        .WIDTH (1),
        .DEPTH (CELLS)
    ) u_grid_a (
        .i_clk   (i_clk),
        .i_we    (w_we_a),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_a)
    );

    lag_ram #(
        .WIDTH (1),
        .DEPTH (CELLS)
    ) u_grid_b (
        .i_clk   (i_clk),
        .i_we    (w_we_b),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_b)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_cnt == SW'(CELLS - 1)) begin
                    n_state = r_report ? ST_FETCH : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    case (t_func'(i_func))
                        FN_CLEAR: n_state = ST_CLEAR;
                        FN_TICK:  n_state = ST_TICK;
                        default:  n_state = ST_FETCH;
                    endcase
                end
            end
            ST_TICK: begin
                if (r_cnt == SW'(TICK_LAST)) begin
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: n_state = ST_DONE;
            ST_DONE:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        n_cnt     = r_cnt;
        n_report  = r_report;
        n_front_b = r_front_b;
        n_live    = r_live;
        n_acc     = r_acc;
        n_gen     = r_gen;
        n_crow    = r_crow;
        n_ccol    = r_ccol;
        n_cidx    = r_cidx;
        n_sr      = r_sr;
        n_rd_v    = 1'b0;
        n_done    = 1'b0;
        n_alive   = r_alive;
        n_func    = r_func;
        n_inside  = r_inside;
        n_idx     = r_idx;
        w_we_a    = 1'b0;
        w_we_b    = 1'b0;
        w_waddr   = r_idx;
        w_wdata   = 1'b0;
        w_raddr   = r_idx;
        busy      = (r_state != ST_IDLE);

        case (r_state)
            ST_CLEAR: begin
                w_we_a  = 1'b1;
                w_we_b  = 1'b1;
                w_waddr = AW'(r_cnt);
                w_wdata = 1'b0;
                n_cnt   = (r_cnt == SW'(CELLS - 1)) ? '0 : r_cnt + SW'(1);
            end
            ST_IDLE: begin
                n_cnt  = '0;
                n_acc  = '0;
                n_crow = '0;
                n_ccol = '0;
                n_cidx = '0;
                if (w_accept) begin
                    n_func   = t_func'(i_func);
                    n_inside = w_inside;
                    n_idx    = AW'(32'(i_cell_row) * 32'(MAX_COLS) + 32'(i_cell_col));
                    n_report = 1'b1;
                end
            end
            ST_TICK: begin
                w_raddr = AW'(r_cnt);
                n_rd_v  = (r_cnt < SW'(CELLS));
                n_sr    = {r_sr[SR_LEN-2:0], r_rd_v && w_front_rd};
                n_cnt   = r_cnt + SW'(1);
                if (r_cnt >= SW'(WR_START)) begin
                    w_we_a  = r_front_b;
                    w_we_b  = !r_front_b;
                    w_waddr = r_cidx;
                    w_wdata = w_next;
                    n_acc   = w_acc_inc;
                    n_cidx  = r_cidx + AW'(1);
                    if (r_ccol == CXW'(MAX_COLS - 1)) begin
                        n_ccol = '0;
                        n_crow = r_crow + RXW'(1);
                    end else begin
                        n_ccol = r_ccol + CXW'(1);
                    end
                end
                if (r_cnt == SW'(TICK_LAST)) begin
                    n_front_b = !r_front_b;
                    n_live    = w_acc_inc;
                    n_gen     = r_gen + GEN_W'(1);
                    n_cnt     = '0;
                end
            end
            ST_FETCH: begin
                w_raddr = r_idx;
            end
            ST_DONE: begin
                n_done = 1'b1;
                if (r_func == FN_TOGGLE) begin
                    n_alive = r_inside && !w_front_rd;
                    if (r_inside) begin
                        w_we_a  = !r_front_b;
                        w_we_b  = r_front_b;
                        w_waddr = r_idx;
                        w_wdata = !w_front_rd;
                    end
                end else begin
                    n_alive = r_inside && w_front_rd;
                end
            end
            default: begin
                n_cnt = '0;
            end
        endcase
    end

    // register file
    always_comb begin
        n_cols = r_cols;
        n_rows = r_rows;
        if (w_cfg_wr) begin
            if (paddr[2] == CFG_ROWS) begin
                n_rows = pwdata[CFG_W-1:0];
            end else begin
                n_cols = pwdata[CFG_W-1:0];
            end
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == CFG_COLS) ? APB_DW'(r_cols) : APB_DW'(r_rows);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_cnt     <= '0;
            r_report  <= 1'b0;
            r_front_b <= 1'b0;
            r_live    <= '0;
            r_acc     <= '0;
            r_gen     <= '0;
            r_crow    <= '0;
            r_ccol    <= '0;
            r_cidx    <= '0;
            r_rd_v    <= 1'b0;
            r_done    <= 1'b0;
            r_cols    <= CFG_DIM_RST;
            r_rows    <= CFG_DIM_RST;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_report  <= n_report;
            r_front_b <= n_front_b;
            r_live    <= n_live;
            r_acc     <= n_acc;
            r_gen     <= n_gen;
            r_crow    <= n_crow;
            r_ccol    <= n_ccol;
            r_cidx    <= n_cidx;
            r_rd_v    <= n_rd_v;
            r_done    <= n_done;
            r_cols    <= n_cols;
            r_rows    <= n_rows;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sr     <= n_sr;
        r_alive  <= n_alive;
        r_func   <= n_func;
        r_inside <= n_inside;
        r_idx    <= n_idx;
    end

    assign o_done              = r_done;
    assign o_cell_alive        = r_alive;
    assign o_living_total      = r_live;
    assign o_generation_number = r_gen;

endmodule

@@ hw/rtl/lag_ram.sv @@
// ----------------------------------------------------------------------------
// lag_ram
// single port write, single port read ram with registered read data
// ----------------------------------------------------------------------------
module lag_ram
    import lag_pkg::*;
#(
    parameter int WIDTH = 1,
    parameter int DEPTH = MAX_COLS_DEF * MAX_ROWS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
